>>> rtl/core/point_in_polygon_test_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the point-in-polygon core
// Short forms for the concurrent checks of the core, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define PIP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("point_in_polygon_test_core: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("point_in_polygon_test_core: next-cycle check failed");

`endif

>>> rtl/core/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types, command codes and constants of the point-in-polygon core.
// ----------------------------------------------------------------------------
package pip_pkg;

  // Default sizing of the core.
  localparam int COORD_BITS_DEF   = 24;
  localparam int MAX_VERTICES_DEF = 64;

  // Command field of an input beat.
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TEST   = 2'd2;

  // Result fields.
  localparam int TAG_W   = 16;
  localparam int CROSS_W = 7;
  localparam logic [CROSS_W-1:0] CROSS_MAX = '1;

  // Reach of the test ray along the wire axis, in the units of the coordinates.
  localparam int RAY_REACH = 160000000;
  localparam int RAY_W     = $clog2(RAY_REACH) + 1;

  // Width of the ray end point and of differences taken against it.
  function automatic int ray_span_bits(int coord_bits);
    int m;
    m = (coord_bits > RAY_W - 1) ? coord_bits : RAY_W - 1;
    return m + 2;
  endfunction

  // Status of the shared edge unit, seen by the sequencer.
  typedef struct packed {
    logic vld;   // an edge result is present this cycle
    logic hit;   // that edge meets the ray
    logic busy;  // an edge is still in flight
  } edge_stat_t;

endpackage

>>> rtl/core/pip_in_if.sv
// ----------------------------------------------------------------------------
// pip_in_if
// Input channel of the point-in-polygon core: command, coordinates and tag.
// ----------------------------------------------------------------------------
interface pip_in_if import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();

  logic                         valid;
  logic                         ready;
  logic [CMD_W-1:0]             cmd;
  logic signed [COORD_BITS-1:0] coord_w;
  logic signed [COORD_BITS-1:0] coord_t;
  logic [TAG_W-1:0]             hit_tag;

  modport source (output valid, cmd, coord_w, coord_t, hit_tag, input ready);
  modport sink   (input valid, cmd, coord_w, coord_t, hit_tag, output ready);

endinterface

>>> rtl/core/pip_out_if.sv
// ----------------------------------------------------------------------------
// pip_out_if
// Result channel of the point-in-polygon core: inside flag, count and tag.
// ----------------------------------------------------------------------------
interface pip_out_if import pip_pkg::*; ();

  logic               valid;
  logic               ready;
  logic               inside_res;
  logic [CROSS_W-1:0] crossings;
  logic [TAG_W-1:0]   tag_out;

  modport source (output valid, inside_res, crossings, tag_out, input ready);
  modport sink   (input valid, inside_res, crossings, tag_out, output ready);

endinterface

>>> rtl/core/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pip_ram import pip_pkg::*; #(
  parameter int WIDTH = 2 * COORD_BITS_DEF,
  parameter int DEPTH = MAX_VERTICES_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/pip_edge_unit.sv
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared edge unit: tests one polygon edge per cycle against the test ray in
// a three-stage pipeline (differences, products, orientation and decision).
// ----------------------------------------------------------------------------
module pip_edge_unit import pip_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int EW        = ray_span_bits(COORD_BITS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         edge_vld,
  input  logic signed [COORD_BITS-1:0] a_w,
  input  logic signed [COORD_BITS-1:0] a_t,
  input  logic signed [COORD_BITS-1:0] b_w,
  input  logic signed [COORD_BITS-1:0] b_t,
  input  logic signed [COORD_BITS-1:0] p_w,
  input  logic signed [COORD_BITS-1:0] p_t,
  input  logic signed [EW-1:0]         e_w,
  output edge_stat_t                   stat
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + EW;
  localparam int VW = PW + 1;

  // Orientation codes of a point triple.
  localparam logic [1:0] ORI_COL = 2'd0;
  localparam logic [1:0] ORI_POS = 2'd1;
  localparam logic [1:0] ORI_NEG = 2'd2;

  // Stage 1 registers.
  logic                 s1_vld;
  logic signed [DW-1:0] s1_dt, s1_dw, s1_dpw, s1_dpt;
  logic signed [EW-1:0] s1_dew;
  logic [1:0]           s1_o3, s1_o4;
  logic                 s1_box_p, s1_box_e, s1_box_a, s1_box_b;

  // Stage 2 registers.
  logic                 s2_vld;
  logic signed [PW-1:0] s2_m1, s2_m2, s2_m3;
  logic [1:0]           s2_o3, s2_o4;
  logic                 s2_box_p, s2_box_e, s2_box_a, s2_box_b;

  // Stage 1 combinational terms.
  logic signed [EW-1:0] aw_e, bw_e;
  logic                 pw_in, ew_in, pt_in;
  logic                 box_a, box_b;
  logic [1:0]           o3, o4;

  // Stage 3 combinational terms.
  logic signed [VW-1:0] v1, v2;
  logic [1:0]           o1, o2;
  logic                 hit;

  // Bounding-box tests and the orientations against the horizontal ray,
  // whose sign only depends on the vertex time coordinate.
  always_comb begin
    aw_e  = EW'(a_w);
    bw_e  = EW'(b_w);
    pw_in = (p_w >= a_w && p_w <= b_w) || (p_w <= a_w && p_w >= b_w);
    ew_in = (e_w >= aw_e && e_w <= bw_e) || (e_w <= aw_e && e_w >= bw_e);
    pt_in = (p_t >= a_t && p_t <= b_t) || (p_t <= a_t && p_t >= b_t);
    box_a = (a_w >= p_w) && (aw_e <= e_w) && (a_t == p_t);
    box_b = (b_w >= p_w) && (bw_e <= e_w) && (b_t == p_t);
    if (a_t == p_t) begin
      o3 = ORI_COL;
    end else if (a_t < p_t) begin
      o3 = ORI_POS;
    end else begin
      o3 = ORI_NEG;
    end
    if (b_t == p_t) begin
      o4 = ORI_COL;
    end else if (b_t < p_t) begin
      o4 = ORI_POS;
    end else begin
      o4 = ORI_NEG;
    end
  end

  // Stage 1: coordinate differences and box flags.
  always_ff @(posedge clk) begin
    s1_dt    <= DW'(b_t) - DW'(a_t);
    s1_dw    <= DW'(b_w) - DW'(a_w);
    s1_dpw   <= DW'(p_w) - DW'(b_w);
    s1_dpt   <= DW'(p_t) - DW'(b_t);
    s1_dew   <= e_w - bw_e;
    s1_o3    <= o3;
    s1_o4    <= o4;
    s1_box_p <= pw_in && pt_in;
    s1_box_e <= ew_in && pt_in;
    s1_box_a <= box_a;
    s1_box_b <= box_b;
  end

  // Stage 2: the three cross-product terms.
  always_ff @(posedge clk) begin
    s2_m1    <= PW'(s1_dt) * PW'(s1_dpw);
    s2_m2    <= PW'(s1_dt) * PW'(s1_dew);
    s2_m3    <= PW'(s1_dw) * PW'(s1_dpt);
    s2_o3    <= s1_o3;
    s2_o4    <= s1_o4;
    s2_box_p <= s1_box_p;
    s2_box_e <= s1_box_e;
    s2_box_a <= s1_box_a;
    s2_box_b <= s1_box_b;
  end

  // Valid bits of the two register stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= edge_vld;
      s2_vld <= s1_vld;
    end
  end

  // Stage 3: orientation of both ray ends against the edge, then the
  // general crossing rule and the collinear on-segment cases.
  always_comb begin
    v1 = VW'(s2_m1) - VW'(s2_m3);
    v2 = VW'(s2_m2) - VW'(s2_m3);
    if (v1 == '0) begin
      o1 = ORI_COL;
    end else if (v1[VW-1]) begin
      o1 = ORI_NEG;
    end else begin
      o1 = ORI_POS;
    end
    if (v2 == '0) begin
      o2 = ORI_COL;
    end else if (v2[VW-1]) begin
      o2 = ORI_NEG;
    end else begin
      o2 = ORI_POS;
    end
    hit = ((o1 != o2) && (s2_o3 != s2_o4)) ||
          ((o1 == ORI_COL) && s2_box_p) ||
          ((o2 == ORI_COL) && s2_box_e) ||
          ((s2_o3 == ORI_COL) && s2_box_a) ||
          ((s2_o4 == ORI_COL) && s2_box_b);
  end

  assign stat.vld  = s2_vld;
  assign stat.hit  = hit;
  assign stat.busy = s1_vld || s2_vld;

endmodule

>>> rtl/core/point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core
// Vertices are appended to an on-chip store with command 1 and dropped with
// command 0; command 2 tests a point by casting a ray 160000000 units along
// the positive wire axis and counting the edges of the closed outline that
// it meets, including collinear touches. Odd counts report inside, an empty
// polygon reports outside, and appends beyond MAX_VERTICES are ignored. The
// vertex store has one read port and delivers one vertex per cycle, n + 1
// reads for a closed outline of n vertices, into a shared three-stage edge
// unit. The input is not ready while a test runs; the result of a test
// enters the output register in the same cycle as the input is ready again,
// and a finished result waits there while new beats are taken.
// ----------------------------------------------------------------------------
`include "point_in_polygon_test_core_assert.svh"

module point_in_polygon_test_core import pip_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  pip_in_if.sink   item,
  pip_out_if.source result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int EW = ray_span_bits(COORD_BITS);
  localparam int RW = 2 * COORD_BITS;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]    state, state_next;
  logic [NW-1:0] vcount;
  logic [NW-1:0] rd_cnt;
  logic [AW-1:0] rd_addr;
  logic          take, fin;
  logic          store_we;

  // Test point, ray end and tag of the running test.
  logic signed [COORD_BITS-1:0] p_w, p_t;
  logic signed [EW-1:0]         e_w;
  logic [TAG_W-1:0]             tag;

  // Vertex read path.
  logic [RW-1:0]                rdata;
  logic signed [COORD_BITS-1:0] cur_w, cur_t, prev_w, prev_t;
  logic                         d_vld, d_first;
  edge_stat_t                   stat;

  // Crossing count and output register.
  logic [CROSS_W-1:0] cross_cnt;
  logic               cross_par;
  logic               res_vld;
  logic               res_inside;
  logic [CROSS_W-1:0] res_cross;
  logic [TAG_W-1:0]   res_tag;

  assign item.ready = (state == ST_IDLE);
  assign take       = item.valid && item.ready;
  assign store_we   = take && (item.cmd == CMD_APPEND) && (vcount < NW'(MAX_VERTICES));

  // The last read wraps to vertex 0 to close the outline.
  assign rd_addr = (rd_cnt == vcount) ? '0 : rd_cnt[AW-1:0];

  // A test finishes once the pipeline is empty and the output register is free.
  assign fin = (state == ST_DRAIN) && !d_vld && !stat.busy && (!res_vld || result.ready);

  // Vertex store.
  pip_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (vcount[AW-1:0]),
    .wdata ({item.coord_w, item.coord_t}),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign cur_w = $signed(rdata[RW-1:COORD_BITS]);
  assign cur_t = $signed(rdata[COORD_BITS-1:0]);

  // Shared edge unit, fed with one edge per cycle.
  pip_edge_unit #(
    .COORD_BITS (COORD_BITS)
  ) u_edge (
    .clk      (clk),
    .rst      (rst),
    .edge_vld (d_vld && !d_first),
    .a_w      (prev_w),
    .a_t      (prev_t),
    .b_w      (cur_w),
    .b_t      (cur_t),
    .p_w      (p_w),
    .p_t      (p_t),
    .e_w      (e_w),
    .stat     (stat)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && item.cmd == CMD_TEST) begin
          state_next = (vcount == '0) ? ST_DRAIN : ST_WALK;
        end
      end
      ST_WALK: begin
        if (rd_cnt == vcount) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (fin) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      vcount  <= '0;
      rd_cnt  <= '0;
      d_vld   <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      state <= state_next;
      d_vld <= (state == ST_WALK);
      if (take && item.cmd == CMD_CLEAR) begin
        vcount <= '0;
      end else if (store_we) begin
        vcount <= vcount + 1'b1;
      end
      if (take && item.cmd == CMD_TEST) begin
        rd_cnt <= '0;
      end else if (state == ST_WALK) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      if (fin) begin
        res_vld <= 1'b1;
      end else if (result.ready) begin
        res_vld <= 1'b0;
      end
    end
  end

  // Test operands, held for the whole walk.
  always_ff @(posedge clk) begin
    if (take && item.cmd == CMD_TEST) begin
      p_w <= item.coord_w;
      p_t <= item.coord_t;
      e_w <= EW'(item.coord_w) + EW'(RAY_REACH);
      tag <= item.hit_tag;
    end
  end

  // The previous vertex forms the start of the next edge.
  always_ff @(posedge clk) begin
    d_first <= (rd_cnt == '0);
    if (d_vld) begin
      prev_w <= cur_w;
      prev_t <= cur_t;
    end
  end

  // Saturating crossing count with a separate parity bit.
  always_ff @(posedge clk) begin
    if (take && item.cmd == CMD_TEST) begin
      cross_cnt <= '0;
      cross_par <= 1'b0;
    end else if (stat.vld && stat.hit) begin
      cross_par <= !cross_par;
      if (cross_cnt != CROSS_MAX) begin
        cross_cnt <= cross_cnt + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (fin) begin
      res_inside <= cross_par;
      res_cross  <= cross_cnt;
      res_tag    <= tag;
    end
  end

  assign result.valid      = res_vld;
  assign result.inside_res = res_inside;
  assign result.crossings  = res_cross;
  assign result.tag_out    = res_tag;

  // Checks on the sequencer and the vertex store.
  `PIP_ASSERT_IMP(a_vcount_cap, 1'b1, vcount <= NW'(MAX_VERTICES))
  `PIP_ASSERT_IMP(a_idle_quiet, state == ST_IDLE, !d_vld && !stat.vld)
  `PIP_ASSERT_IMP(a_walk_range, state == ST_WALK, rd_cnt <= vcount)
  `PIP_ASSERT_NEXT(a_test_start, take && item.cmd == CMD_TEST, state != ST_IDLE)

endmodule

>>> dv/tb_point_in_polygon_test_core.sv
// ----------------------------------------------------------------------------
// tb_point_in_polygon_test_core
// Loads polygons into the core and tests points against them. A local
// ray-casting predictor computes the inside flag, the number of crossed edges
// and the tag for every test beat. Results are checked in order against it,
// with random gaps on the input side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_point_in_polygon_test_core import pip_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     COORD_BITS   = COORD_BITS_DEF;
  localparam int     MAX_VERTICES = MAX_VERTICES_DEF;
  localparam int     ITEM_TARGET  = 1550;
  localparam int     MAX_WAIT     = 11;
  localparam int     DRAIN_CYCLES = MAX_VERTICES + 16;
  localparam int     REPORT_LIMIT = 10;
  localparam longint COORD_HI     = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_LO     = -(longint'(1) << (COORD_BITS - 1));
  localparam longint RAY_LEN      = RAY_REACH;

  // Command code that the core leaves alone.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {TURN_FLAT, TURN_POS, TURN_NEG} turn_t;

  typedef struct packed {
    logic [CMD_W-1:0]             cmd;
    logic signed [COORD_BITS-1:0] w;
    logic signed [COORD_BITS-1:0] t;
    logic [TAG_W-1:0]             tag;
  } pip_beat_t;

  typedef struct packed {
    logic               in_poly;
    logic [CROSS_W-1:0] hits;
    logic [TAG_W-1:0]   tag;
  } verdict_t;

  logic clk = 1'b0;
  logic rst;

  pip_in_if #(.COORD_BITS(COORD_BITS)) in_ch ();
  pip_out_if out_ch ();

  point_in_polygon_test_core #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (in_ch),
    .result(out_ch)
  );

  always #5ns clk = ~clk;

  // Beats waiting to be driven and verdicts waiting to come back.
  pip_beat_t beat_q[$];
  verdict_t  verdict_q[$];
  int        beats_taken = 0;
  int        fail_count  = 0;
  int        report_count = 0;

  // Polygon as the core should hold it.
  longint outline_w[MAX_VERTICES];
  longint outline_t[MAX_VERTICES];
  int     outline_n = 0;

  // Polygon as the stimulus generator has built it so far.
  longint plan_w[$];
  longint plan_t[$];
  int     counted_items = 0;

  // Sign of the turn a -> b -> c.
  function automatic turn_t turn_dir(input longint aw, at, bw, bt, cw, ct);
    longint v;
    v = (bt - at) * (cw - bw) - (bw - aw) * (ct - bt);
    if (v == 0) return TURN_FLAT;
    return (v > 0) ? TURN_POS : TURN_NEG;
  endfunction

  // Point b lies in the bounding box of a and c.
  function automatic bit in_box(input longint aw, at, bw, bt, cw, ct);
    return bw <= ((aw > cw) ? aw : cw) && bw >= ((aw < cw) ? aw : cw) &&
           bt <= ((at > ct) ? at : ct) && bt >= ((at < ct) ? at : ct);
  endfunction

  // Segment a-b against the ray segment from p to p + reach along w.
  function automatic bit seg_meets_ray(input longint aw, at, bw, bt, pw, pt);
    longint ew;
    turn_t  o1, o2, o3, o4;
    ew = pw + RAY_LEN;
    o1 = turn_dir(aw, at, bw, bt, pw, pt);
    o2 = turn_dir(aw, at, bw, bt, ew, pt);
    o3 = turn_dir(pw, pt, ew, pt, aw, at);
    o4 = turn_dir(pw, pt, ew, pt, bw, bt);
    if (o1 != o2 && o3 != o4) return 1'b1;
    if (o1 == TURN_FLAT && in_box(aw, at, pw, pt, bw, bt)) return 1'b1;
    if (o2 == TURN_FLAT && in_box(aw, at, ew, pt, bw, bt)) return 1'b1;
    if (o3 == TURN_FLAT && in_box(pw, pt, aw, at, ew, pt)) return 1'b1;
    if (o4 == TURN_FLAT && in_box(pw, pt, bw, bt, ew, pt)) return 1'b1;
    return 1'b0;
  endfunction

  // Update the polygon for one accepted beat and queue the verdict of a test.
  function automatic void apply_beat(input pip_beat_t b);
    int       hits;
    int       nx;
    verdict_t v;
    case (b.cmd)
      CMD_CLEAR: outline_n = 0;
      CMD_APPEND: begin
        if (outline_n < MAX_VERTICES) begin
          outline_w[outline_n] = longint'(b.w);
          outline_t[outline_n] = longint'(b.t);
          outline_n++;
        end
      end
      CMD_TEST: begin
        hits = 0;
        for (int i = 0; i < outline_n; i++) begin
          nx = (i + 1 == outline_n) ? 0 : i + 1;
          if (seg_meets_ray(outline_w[i], outline_t[i], outline_w[nx], outline_t[nx],
                            longint'(b.w), longint'(b.t)))
            hits++;
        end
        v.in_poly = hits[0];
        v.hits    = (hits > int'(CROSS_MAX)) ? CROSS_MAX : hits[CROSS_W-1:0];
        v.tag     = b.tag;
        verdict_q.insert(verdict_q.size(), v);
      end
      default: ;
    endcase
  endfunction

  // Queue one beat and track what the core will hold after it.
  task automatic add_beat(input logic [CMD_W-1:0] c, input longint w, t, input int tag);
    pip_beat_t b;
    b.cmd = c;
    b.w   = w[COORD_BITS-1:0];
    b.t   = t[COORD_BITS-1:0];
    b.tag = tag[TAG_W-1:0];
    beat_q.insert(beat_q.size(), b);
    case (c)
      CMD_CLEAR: begin
        plan_w.delete();
        plan_t.delete();
        counted_items++;
      end
      CMD_APPEND: begin
        if (plan_w.size() < MAX_VERTICES) begin
          plan_w.insert(plan_w.size(), longint'(b.w));
          plan_t.insert(plan_t.size(), longint'(b.t));
          counted_items++;
        end
      end
      CMD_TEST: counted_items++;
      default: ;
    endcase
  endtask

  // Random coordinate around mid, or over the whole range for a negative span.
  function automatic longint rand_coord(input longint mid, input int span);
    longint v;
    if (span < 0)
      v = longint'($urandom_range(0, 32'hFF_FFFF)) + COORD_LO;
    else
      v = mid + longint'($urandom_range(0, 2 * span)) - span;
    if (v > COORD_HI) v = COORD_HI;
    if (v < COORD_LO) v = COORD_LO;
    return v;
  endfunction

  // One random phase: usually a fresh polygon, then a handful of test points.
  task automatic random_phase();
    int     n, span, tests, k, j;
    longint cw, ct, pw, pt;
    k = $urandom_range(0, 99);
    if (k < 70) n = $urandom_range(0, 12);
    else if (k < 92) n = $urandom_range(13, MAX_VERTICES);
    else n = $urandom_range(MAX_VERTICES - 4, MAX_VERTICES + 6);
    case ($urandom_range(0, 3))
      0: span = 8;
      1: span = 200;
      2: span = 100000;
      default: span = -1;
    endcase
    cw = rand_coord(0, -1);
    ct = rand_coord(0, -1);
    // Skipping the clear now and then extends the previous polygon.
    if ($urandom_range(0, 9) != 0)
      add_beat(CMD_CLEAR, rand_coord(0, -1), rand_coord(0, -1), $urandom_range(0, 65535));
    for (int i = 0; i < n; i++)
      add_beat(CMD_APPEND, rand_coord(cw, span), rand_coord(ct, span),
               $urandom_range(0, 65535));
    tests = $urandom_range(1, 8);
    for (int i = 0; i < tests; i++) begin
      k = plan_w.size();
      j = (k > 0) ? $urandom_range(0, k - 1) : 0;
      case ((k > 0) ? $urandom_range(0, 5) : 3)
        0: begin
          pw = plan_w[j];
          pt = plan_t[j];
        end
        1: begin
          pw = ($urandom_range(0, 1) == 0) ? rand_coord(cw, span) : rand_coord(0, -1);
          pt = plan_t[j];
        end
        2: begin
          pw = (plan_w[j] + plan_w[(j + 1) % k]) >>> 1;
          pt = (plan_t[j] + plan_t[(j + 1) % k]) >>> 1;
        end
        5: begin
          pw = rand_coord(0, -1);
          pt = rand_coord(0, -1);
        end
        default: begin
          pw = rand_coord(cw, span);
          pt = rand_coord(ct, span);
        end
      endcase
      add_beat(CMD_TEST, pw, pt, $urandom_range(0, 65535));
      if ($urandom_range(0, 14) == 0)
        add_beat(CMD_UNUSED, rand_coord(0, -1), rand_coord(0, -1), $urandom_range(0, 65535));
    end
  endtask

  // Input driver: presents queued beats with a random gap after each one.
  always @(posedge clk) begin : drive_items
    pip_beat_t nb;
    int        gap;
    bit        quiet;
    if (rst) begin
      in_ch.valid <= 1'b0;
      gap = 0;
      quiet = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nb.cmd = in_ch.cmd;
        nb.w   = in_ch.coord_w;
        nb.t   = in_ch.coord_t;
        nb.tag = in_ch.hit_tag;
        apply_beat(nb);
        beats_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap != 0) begin
          in_ch.valid <= 1'b0;
          gap--;
        end else if (beat_q.size() != 0) begin
          nb = beat_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.cmd     <= nb.cmd;
          in_ch.coord_w <= nb.w;
          in_ch.coord_t <= nb.t;
          in_ch.hit_tag <= nb.tag;
          if ($urandom_range(0, 39) == 0) quiet = !quiet;
          gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat, then stalls ready for a random time.
  always @(posedge clk) begin : watch_results
    verdict_t got, want;
    int       hold;
    int       stall;
    bit       quiet;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold = 0;
      quiet = 1'b0;
    end else if (out_ch.valid && out_ch.ready) begin
      got.in_poly = out_ch.inside_res;
      got.hits    = out_ch.crossings;
      got.tag     = out_ch.tag_out;
      if (verdict_q.size() == 0) begin
        fail_count++;
        report_count++;
        if (report_count <= REPORT_LIMIT)
          $display("unexpected result: inside=%0b crossings=%0d tag=%h",
                   got.in_poly, got.hits, got.tag);
      end else begin
        want = verdict_q.pop_front();
        if (got.in_poly !== want.in_poly || got.hits !== want.hits || got.tag !== want.tag)
        begin
          fail_count++;
          report_count++;
          if (report_count <= REPORT_LIMIT)
            $display("result mismatch: expected inside=%0b crossings=%0d tag=%h, %s",
                     want.in_poly, want.hits, want.tag,
                     $sformatf("got inside=%0b crossings=%0d tag=%h",
                               got.in_poly, got.hits, got.tag));
        end
      end
      if ($urandom_range(0, 39) == 0) quiet = !quiet;
      stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      out_ch.ready <= (stall == 0);
      hold = stall;
    end else if (!out_ch.ready) begin
      if (hold <= 1) out_ch.ready <= 1'b1;
      else hold--;
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    int beat_total;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_CLEAR;
    in_ch.coord_w = '0;
    in_ch.coord_t = '0;
    in_ch.hit_tag = '0;
    out_ch.ready  = 1'b0;

    // Empty store after reset, and the unused command.
    add_beat(CMD_TEST, 0, 0, 0);
    add_beat(CMD_UNUSED, COORD_HI, COORD_LO, 16'hFFFF);
    // One vertex, then two: degenerate edges.
    add_beat(CMD_APPEND, 0, 0, 16'h1234);
    add_beat(CMD_TEST, -5, 0, 1);
    add_beat(CMD_TEST, 0, 0, 2);
    add_beat(CMD_APPEND, 16, 16, 0);
    add_beat(CMD_TEST, -8, 8, 3);
    add_beat(CMD_TEST, -8, 16, 4);
    // Triangle: inside, on an edge, ray along an edge, ray through the apex.
    add_beat(CMD_CLEAR, 0, 0, 0);
    add_beat(CMD_APPEND, -100, -100, 0);
    add_beat(CMD_APPEND, 100, -100, 0);
    add_beat(CMD_APPEND, 0, 100, 0);
    add_beat(CMD_TEST, 0, 0, 16'hFFFF);
    add_beat(CMD_TEST, 0, -100, 5);
    add_beat(CMD_TEST, -200, -100, 6);
    add_beat(CMD_TEST, 0, 100, 7);
    add_beat(CMD_TEST, -300, 0, 8);
    // Square at the corners of the coordinate range.
    add_beat(CMD_CLEAR, COORD_LO, COORD_HI, 16'hFFFF);
    add_beat(CMD_APPEND, COORD_LO, COORD_LO, 0);
    add_beat(CMD_APPEND, COORD_HI, COORD_LO, 0);
    add_beat(CMD_APPEND, COORD_HI, COORD_HI, 0);
    add_beat(CMD_APPEND, COORD_LO, COORD_HI, 0);
    add_beat(CMD_TEST, 0, 0, 9);
    add_beat(CMD_TEST, COORD_HI, 0, 10);
    add_beat(CMD_TEST, COORD_LO, COORD_HI, 11);

    while (counted_items < ITEM_TARGET)
      random_phase();
    beat_total = beat_q.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (beats_taken < beat_total) @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("tb_point_in_polygon_test_core: PASS");
    end else begin
      $display("tb_point_in_polygon_test_core: FAIL");
    end
    $finish;
  end

  // Hard stop in case the core hangs.
  initial begin : watchdog
    #20_000_000;
    $display("tb_point_in_polygon_test_core: FAIL");
    $finish;
  end

endmodule
